// File: design/udp_ipv4_receive_filter_top_defines.svh
// Assertion macros shared by the UDP/IPv4 receive filter RTL.
`ifndef UDP_IPV4_RECEIVE_FILTER_TOP_DEFINES_SVH
`define UDP_IPV4_RECEIVE_FILTER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define UIRF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("uirf same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define UIRF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("uirf next-cycle check failed");

`endif

// File: design/uirf_pkg.sv
// Types and constants of the UDP/IPv4 receive filter.
package uirf_pkg;

    // Widths of the configuration port and of the length arithmetic.
    localparam int PORT_MATCH_W = 17;
    localparam int CFG_INDEX_W  = 1;
    localparam int LEN_W        = 17;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_PORT_MATCH = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_DEST_PORT_MATCH   = 1'b1;

    // Port match value that accepts any port.
    localparam logic [PORT_MATCH_W-1:0] PORT_ANY = {PORT_MATCH_W{1'b1}};

    // Byte offsets of the header fields of interest.
    localparam int OFF_VERSION  = 0;
    localparam int OFF_PROTOCOL = 9;
    localparam int OFF_SPORT_HI = 20;
    localparam int OFF_SPORT_LO = 21;
    localparam int OFF_DPORT_HI = 22;
    localparam int OFF_DPORT_LO = 23;
    localparam int OFF_ULEN_HI  = 24;
    localparam int OFF_ULEN_LO  = 25;

    // Header sizes and expected values.
    localparam int         HDR_BYTES     = 28;
    localparam int         UDP_HDR_BYTES = 8;
    localparam logic [3:0] IPV4_VERSION  = 4'd4;
    localparam logic [7:0] PROTO_UDP     = 8'd17;

    // Verdict codes.
    typedef enum logic [2:0] {
        VERDICT_OK        = 3'd0,
        VERDICT_SHORT     = 3'd1,
        VERDICT_NOT_UDP   = 3'd2,
        VERDICT_TRUNCATED = 3'd3,
        VERDICT_BAD_SPORT = 3'd4,
        VERDICT_BAD_DPORT = 3'd5
    } verdict_t;

    // Header fields gathered while a packet streams in.
    typedef struct packed {
        logic [3:0]  ip_version;
        logic [7:0]  ip_protocol;
        logic [15:0] seen_source_port;
        logic [15:0] seen_dest_port;
        logic [15:0] udp_length;
    } hdr_t;

    // Input transaction payload.
    typedef struct packed {
        logic [7:0] packet_byte;
        logic       last_byte;
    } packet_t;

    // Result transaction payload.
    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic       verdict_valid;
        logic [2:0] verdict;
        logic [9:0] payload_length;
    } result_t;

endpackage

// File: design/uirf_stream_if.sv
// Valid/ready stream channel carrying one payload per transaction.
interface uirf_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: design/uirf_classify.sv
// Per-byte classification: payload flag and end-of-packet verdict.
module uirf_classify
    import uirf_pkg::*;
#(
    parameter int CAPTURE_BYTES = 1024,
    parameter int OFFSET_W      = 11
)
(
    input  logic [OFFSET_W-1:0]     byte_offset,
    input  hdr_t                    hdr,
    input  logic [PORT_MATCH_W-1:0] source_match,
    input  logic [PORT_MATCH_W-1:0] dest_match,
    input  packet_t                 item,
    output logic                    captured,
    output result_t                 res
);

    logic [LEN_W-1:0] pos_ext;
    logic [LEN_W-1:0] got;
    logic [LEN_W-1:0] body_len;
    logic             len_ok;
    logic             in_payload;
    verdict_t         verdict;

    // A match value of all ones accepts any port; other negatives never match.
    function automatic logic port_ok(logic [PORT_MATCH_W-1:0] match, logic [15:0] seen);
        logic ok;
        if (match == PORT_ANY)
        begin
            ok = 1'b1;
        end
        else
        begin
            ok = !match[PORT_MATCH_W-1] && (match[15:0] == seen);
        end
        return ok;
    endfunction

    // Position and length arithmetic.
    always_comb
    begin
        captured = byte_offset < OFFSET_W'(CAPTURE_BYTES);
        pos_ext  = LEN_W'(byte_offset);
        got      = captured ? pos_ext + LEN_W'(1) : pos_ext;
        len_ok   = hdr.udp_length >= 16'(UDP_HDR_BYTES);
        body_len = LEN_W'(hdr.udp_length) - LEN_W'(UDP_HDR_BYTES);
        in_payload = captured && len_ok && (pos_ext >= LEN_W'(HDR_BYTES))
                     && ((pos_ext - LEN_W'(HDR_BYTES)) < body_len);
    end

    // Ordered checks for the verdict on the last byte.
    always_comb
    begin
        if (got < LEN_W'(HDR_BYTES))
        begin
            verdict = VERDICT_SHORT;
        end
        else if (hdr.ip_version != IPV4_VERSION || hdr.ip_protocol != PROTO_UDP)
        begin
            verdict = VERDICT_NOT_UDP;
        end
        else if (!len_ok || body_len > (got - LEN_W'(HDR_BYTES)))
        begin
            verdict = VERDICT_TRUNCATED;
        end
        else if (!port_ok(source_match, hdr.seen_source_port))
        begin
            verdict = VERDICT_BAD_SPORT;
        end
        else if (!port_ok(dest_match, hdr.seen_dest_port))
        begin
            verdict = VERDICT_BAD_DPORT;
        end
        else
        begin
            verdict = VERDICT_OK;
        end
    end

    // Assemble the result transaction.
    always_comb
    begin
        res.payload_byte   = item.packet_byte;
        res.payload_valid  = in_payload;
        res.verdict_valid  = item.last_byte;
        res.verdict        = item.last_byte ? verdict : VERDICT_OK;
        res.payload_length = (item.last_byte && verdict == VERDICT_OK) ? body_len[9:0] : 10'd0;
    end

endmodule

// File: design/udp_ipv4_receive_filter_top.sv
// Top level of the UDP/IPv4 receive filter.
// The filter takes one packet byte per transaction and returns one result per byte in the next
// cycle: the byte echoed, a flag for bytes inside the UDP payload, and on the last byte a
// verdict with the payload length. It sustains one byte per clock while results are taken; the
// only storage in the path is the byte counter with the captured header fields and the result
// register. A new byte enters when the result register is empty or when its waiting result is
// taken in the same cycle, so a stalled output holds the input off. The IP header is
// assumed to be 20 bytes without options, checksums are not checked, and bytes beyond
// CAPTURE_BYTES are echoed but never flagged. The port match registers reset to "any" and
// must only be written while no packet is in flight.
`include "udp_ipv4_receive_filter_top_defines.svh"

module udp_ipv4_receive_filter_top
    import uirf_pkg::*;
#(
    parameter int CAPTURE_BYTES = 1024
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    uirf_stream_if.sink             packet,
    uirf_stream_if.source           result,
    input  logic                    cfg_we,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [PORT_MATCH_W-1:0] cfg_data
);

    localparam int OFFSET_W = $clog2(CAPTURE_BYTES + 1);

    logic [PORT_MATCH_W-1:0] source_match_reg;
    logic [PORT_MATCH_W-1:0] dest_match_reg;
    logic [OFFSET_W-1:0]     byte_offset_reg;
    logic [OFFSET_W-1:0]     byte_offset_next;
    hdr_t                    hdr_reg;
    hdr_t                    hdr_next;
    result_t                 result_reg;
    logic                    result_valid_reg;
    result_t                 res_comb;
    packet_t                 item;
    logic                    captured;
    logic                    accept;

    assign item   = packet.payload;
    assign accept = packet.valid && packet.ready;

    // A byte enters when the result register is empty or being drained.
    assign packet.ready   = !result_valid_reg || result.ready;
    assign result.valid   = result_valid_reg;
    assign result.payload = result_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_match_reg <= PORT_ANY;
            dest_match_reg   <= PORT_ANY;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SOURCE_PORT_MATCH: source_match_reg <= cfg_data;
                REG_DEST_PORT_MATCH:   dest_match_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    uirf_classify #(
        .CAPTURE_BYTES (CAPTURE_BYTES),
        .OFFSET_W      (OFFSET_W)
    ) u_classify (
        .byte_offset  (byte_offset_reg),
        .hdr          (hdr_reg),
        .source_match (source_match_reg),
        .dest_match   (dest_match_reg),
        .item         (item),
        .captured     (captured),
        .res          (res_comb)
    );

    // Header capture and byte counting; everything clears after the last byte.
    always_comb
    begin
        hdr_next         = hdr_reg;
        byte_offset_next = byte_offset_reg;
        if (captured)
        begin
            byte_offset_next = byte_offset_reg + OFFSET_W'(1);
            case (byte_offset_reg)
                OFFSET_W'(OFF_VERSION):  hdr_next.ip_version  = item.packet_byte[7:4];
                OFFSET_W'(OFF_PROTOCOL): hdr_next.ip_protocol = item.packet_byte;
                OFFSET_W'(OFF_SPORT_HI): hdr_next.seen_source_port[15:8] = item.packet_byte;
                OFFSET_W'(OFF_SPORT_LO): hdr_next.seen_source_port[7:0]  = item.packet_byte;
                OFFSET_W'(OFF_DPORT_HI): hdr_next.seen_dest_port[15:8]   = item.packet_byte;
                OFFSET_W'(OFF_DPORT_LO): hdr_next.seen_dest_port[7:0]    = item.packet_byte;
                OFFSET_W'(OFF_ULEN_HI):  hdr_next.udp_length[15:8]       = item.packet_byte;
                OFFSET_W'(OFF_ULEN_LO):  hdr_next.udp_length[7:0]        = item.packet_byte;
                default: ;
            endcase
        end
        if (item.last_byte)
        begin
            hdr_next         = '0;
            byte_offset_next = '0;
        end
    end

    // Packet state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_offset_reg <= '0;
            hdr_reg         <= '0;
        end
        else if (accept)
        begin
            byte_offset_reg <= byte_offset_next;
            hdr_reg         <= hdr_next;
        end
    end

    // Result register: loads on every accepted transaction, empties when taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= res_comb;
        end
    end

    // Checks on the filter's own bookkeeping.
    `UIRF_ASSERT_NEXT(a_clear_after_last, clk, rst_n,
        accept && item.last_byte, byte_offset_reg == '0 && hdr_reg == '0)
    `UIRF_ASSERT_SAME(a_offset_bounded, clk, rst_n,
        1'b1, byte_offset_reg <= OFFSET_W'(CAPTURE_BYTES))
    `UIRF_ASSERT_SAME(a_no_verdict_mid_packet, clk, rst_n,
        result_valid_reg && !result_reg.verdict_valid,
        result_reg.verdict == VERDICT_OK && result_reg.payload_length == 10'd0)
    `UIRF_ASSERT_SAME(a_length_only_when_ok, clk, rst_n,
        result_valid_reg && result_reg.verdict != VERDICT_OK,
        result_reg.payload_length == 10'd0)

endmodule
